>>> src/malwf_pkg.sv
// shared types and constants for the allow-list wake filter
package malwf_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned PREFIX_W = 16;
  localparam int unsigned REP_W    = 11;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [PREFIX_W-1:0] PREFIX_RESET  = 16'h7eed;
  localparam logic [LEN_W-1:0]    MIN_LEN_RESET = 16'd40;

  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_PREFIX   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME_LENGTH = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME      = 3'd0,
    CMD_POLL       = 3'd1,
    CMD_SYNC       = 3'd2,
    CMD_CLEAR_ALL  = 3'd3,
    CMD_LOCK       = 3'd4,
    CMD_CLEAR_NEXT = 3'd5,
    CMD_UNKNOWN    = 3'd6,
    CMD_TIMEOUT    = 3'd7
  } cmd_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_ACT  = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

>>> src/malwf_ram.sv
// generic single-write, single-read ram with registered read data
module malwf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/mac_allow_list_wake_filter_core.sv
// top level of the allow-list wake filter: command handling, list search and compaction
//
// Takes one request at a time. Commands and silence timeouts go straight to the result.
// A frame that passes the listen, length and prefix checks walks the address list
// through the one read port of the list ram, reading and then comparing one entry at a
// time until a match or the end of the list; forgetting an address then moves every
// later entry down one slot. The result stays in an output register, so a new request
// is taken while the last result still waits. The list needs no clearing after reset;
// clear all simply empties the count.
module mac_allow_list_wake_filter_core
  import malwf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // device_address[47:0], frame_length[63:48]
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // host_awake[0], reported_count[11:1],
                                             // wake_pulse[12], link_up[13], zero[15:14]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  state_t state_r, state_nxt;

  logic [PREFIX_W-1:0] prefix_r;
  logic [LEN_W-1:0]    min_len_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    shown_r, shown_nxt;
  logic awake_r, awake_nxt;
  logic lock_r, lock_nxt;
  logic learn_r, learn_nxt;
  logic forget_r, forget_nxt;
  logic link_r, link_nxt;
  logic listen_r, listen_nxt;
  logic found_r, found_nxt;
  logic pulse_r, pulse_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  logic              in_acc;
  cmd_t              in_cmd;
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  in_len;
  logic              listening;
  logic              examine;
  logic              out_free;
  logic [CNT_W-1:0]  idx_ext;

  assign in_cmd   = cmd_t'(in_tuser);
  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_len   = in_tdata[ADDR_W +: LEN_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign idx_ext    = CNT_W'(idx_r);

  assign listening = (!link_r && !awake_r) || (listen_r && lock_r);
  assign examine   = listening && (in_len >= min_len_r) &&
                     (in_addr[ADDR_W-1 -: PREFIX_W] == prefix_r);

  malwf_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_list_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    shown_nxt  = shown_r;
    awake_nxt  = awake_r;
    lock_nxt   = lock_r;
    learn_nxt  = learn_r;
    forget_nxt = forget_r;
    link_nxt   = link_r;
    listen_nxt = listen_r;
    found_nxt  = found_r;
    pulse_nxt  = pulse_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = addr_r;
    ram_raddr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pulse_nxt = 1'b0;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          addr_nxt  = in_addr;
          state_nxt = S_DONE;
          unique case (in_cmd)
            CMD_FRAME: begin
              if (examine) begin
                state_nxt = (count_r == '0) ? S_ACT : S_RD;
              end
            end
            CMD_TIMEOUT: begin
              if (link_r) begin
                link_nxt  = 1'b0;
                awake_nxt = 1'b0;
              end
            end
            default: begin
              link_nxt   = (in_cmd != CMD_UNKNOWN);
              shown_nxt  = count_r;
              lock_nxt   = (in_cmd == CMD_SYNC) || (in_cmd == CMD_LOCK) ||
                           (in_cmd == CMD_CLEAR_NEXT);
              learn_nxt  = (in_cmd == CMD_SYNC);
              forget_nxt = (in_cmd == CMD_CLEAR_NEXT);
              listen_nxt = (in_cmd == CMD_SYNC) || (in_cmd == CMD_CLEAR_NEXT);
              if (in_cmd == CMD_CLEAR_ALL) begin
                count_nxt = '0;
              end
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (ram_rdata == addr_r) begin
          found_nxt = 1'b1;
          state_nxt = S_ACT;
        end else if (idx_ext + CNT_ONE == count_r) begin
          state_nxt = S_ACT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end

      S_ACT: begin
        state_nxt = S_DONE;
        if (learn_r && !forget_r) begin
          learn_nxt = 1'b0;
          if (!found_r) begin
            if (count_r < CNT_FULL) begin
              ram_we    = 1'b1;
              ram_waddr = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_ONE;
              shown_nxt = count_r + CNT_ONE;
            end else begin
              shown_nxt = count_r;
            end
          end
        end else if (forget_r) begin
          forget_nxt = 1'b0;
          if (found_r) begin
            if (idx_ext + CNT_ONE < count_r) begin
              state_nxt = S_SHRD;
            end else begin
              count_nxt = count_r - CNT_ONE;
              shown_nxt = count_r - CNT_ONE;
            end
          end
        end else if (!lock_r && !awake_r && found_r) begin
          awake_nxt = 1'b1;
          pulse_nxt = 1'b1;
        end
      end

      S_SHRD: begin
        ram_raddr = idx_r + IDX_W'(1);
        state_nxt = S_SHWR;
      end

      S_SHWR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + IDX_W'(1);
        if (idx_ext + CNT_TWO < count_r) begin
          state_nxt = S_SHRD;
        end else begin
          count_nxt = count_r - CNT_ONE;
          shown_nxt = count_r - CNT_ONE;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, link_r, pulse_r, REP_W'(shown_r), awake_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prefix_r    <= PREFIX_RESET;
      min_len_r   <= MIN_LEN_RESET;
      count_r     <= '0;
      shown_r     <= '0;
      awake_r     <= 1'b0;
      lock_r      <= 1'b0;
      learn_r     <= 1'b0;
      forget_r    <= 1'b0;
      link_r      <= 1'b0;
      listen_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      shown_r     <= shown_nxt;
      awake_r     <= awake_nxt;
      lock_r      <= lock_nxt;
      learn_r     <= learn_nxt;
      forget_r    <= forget_nxt;
      link_r      <= link_nxt;
      listen_r    <= listen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ADDRESS_PREFIX) begin
          prefix_r <= cfg_data;
        end else if (cfg_index == REG_MIN_FRAME_LENGTH) begin
          min_len_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    pulse_r    <= pulse_nxt;
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
